[hw/rtl/b32h_pkg.sv]
`timescale 1ns / 1ps

package b32h_pkg;

   localparam int CharWidth     = 8;
   localparam int CountWidth    = 7;
   localparam int CodeWidth     = 2;
   localparam int BufferWidth   = 12;
   localparam int HeldWidth     = 3;
   localparam int SymbolWidth   = 5;
   localparam int CsrAddrWidth  = 3;
   localparam int CsrDataWidth  = 32;

   localparam logic [CountWidth-1:0] ExpectedReset = 7'd20;
   localparam logic [CountWidth-1:0] CountMax      = 7'h7F;

   // status codes
   localparam logic [CodeWidth-1:0] STATUS_OK      = 2'd0;
   localparam logic [CodeWidth-1:0] STATUS_INVALID = 2'd1;
   localparam logic [CodeWidth-1:0] STATUS_COUNT   = 2'd2;

   // register index
   localparam logic [0:0] REG_EXPECTED_BYTES = 1'b0;

   localparam logic [CharWidth-1:0] CHAR_PAD = 8'h3D;

   typedef struct packed {
      logic                  has_byte;
      logic [CharWidth-1:0]  data_byte;
      logic                  has_status;
      logic [CodeWidth-1:0]  status_code;
   } entry_type;

   // {valid, value}
   function automatic logic [SymbolWidth:0] symbol_value(input logic [CharWidth-1:0] c);
      logic [SymbolWidth:0] r;
      r = '0;
      if (c >= 8'h41 && c <= 8'h5A) begin
         r = {1'b1, 5'(c - 8'h41)};
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         r = {1'b1, 5'(c - 8'h61)};
      end else if (c >= 8'h32 && c <= 8'h37) begin
         r = {1'b1, 5'(c - 8'h32 + 8'd26)};
      end
      return r;
   endfunction

   function automatic logic is_blank(input logic [CharWidth-1:0] c);
      return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   function automatic logic [CharWidth-1:0] hex_digit(input logic [3:0] nib);
      logic [CharWidth-1:0] r;
      if (nib < 4'd10) begin
         r = 8'h30 + {4'b0, nib};
      end else begin
         r = 8'h61 + {4'b0, nib} - 8'd10;
      end
      return r;
   endfunction

endpackage

[hw/rtl/b32h_channels.sv]
`timescale 1ns / 1ps

interface b32h_req_if;
   logic                           valid;
   logic                           ready;
   logic [b32h_pkg::CharWidth-1:0] char_code;
   logic                           carries_char;
   logic                           text_end;

   modport source (output valid, output char_code, output carries_char, output text_end,
                   input ready);
   modport sink   (input valid, input char_code, input carries_char, input text_end,
                   output ready);
endinterface

interface b32h_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [b32h_pkg::CharWidth-1:0] out_char;
   logic                           is_status;
   logic [b32h_pkg::CodeWidth-1:0] status_code;
   logic                           run_end;

   modport source (output valid, output out_char, output is_status, output status_code,
                   output run_end, input ready);
   modport sink   (input valid, input out_char, input is_status, input status_code,
                   input run_end, output ready);
endinterface

[hw/rtl/b32h_csr.sv]
`timescale 1ns / 1ps

module b32h_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [b32h_pkg::CsrAddrWidth-1:0] paddr,
   input  logic [b32h_pkg::CsrDataWidth-1:0] pwdata,
   output logic [b32h_pkg::CsrDataWidth-1:0] prdata,
   output logic                              pready,
   output logic [b32h_pkg::CountWidth-1:0]   expected_bytes
);
   import b32h_pkg::*;

   logic [CountWidth-1:0] expected_ff;
   logic [CountWidth-1:0] expected_in;
   logic                  sel_expected;

   assign sel_expected = (paddr[CsrAddrWidth-1:2] == REG_EXPECTED_BYTES);
   assign pready       = 1'b1;

   always_comb begin
      expected_in = expected_ff;
      if (psel && penable && pwrite && sel_expected) begin
         expected_in = pwdata[CountWidth-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_ff <= ExpectedReset;
      end else begin
         expected_ff <= expected_in;
      end
   end

   assign prdata         = sel_expected ? {{(CsrDataWidth-CountWidth){1'b0}}, expected_ff} : '0;
   assign expected_bytes = expected_ff;

endmodule

[hw/rtl/b32h_decode.sv]
`timescale 1ns / 1ps

module b32h_decode (
   input  logic                            clock,
   input  logic                            reset,
   b32h_req_if.sink                        req,
   input  logic [b32h_pkg::CountWidth-1:0] expected_bytes,
   output b32h_pkg::entry_type             entry,
   output logic                            entry_valid,
   input  logic                            entry_ready
);
   import b32h_pkg::*;

   // input register
   logic                  in_valid_ff;
   logic [CharWidth-1:0]  char_ff;
   logic                  carries_ff;
   logic                  end_ff;

   // decoder state
   logic [BufferWidth-1:0] buffer_ff, buffer_in;
   logic [HeldWidth-1:0]   held_ff, held_in;
   logic [CountWidth-1:0]  count_ff, count_in;
   logic                   pad_ff, pad_in;
   logic                   bad_ff, bad_in;
   logic                   started_ff, started_in;
   logic                   space_ff, space_in;

   logic [SymbolWidth:0]   sym;
   logic [BufferWidth-1:0] buffer_shift;
   logic [HeldWidth:0]     held_sum;
   logic [HeldWidth-1:0]   held_rem;
   logic                   produces;
   logic                   advance;
   entry_type              entry_c;

   assign sym          = symbol_value(char_ff);
   assign buffer_shift = {buffer_ff[BufferWidth-SymbolWidth-1:0], sym[SymbolWidth-1:0]};
   assign held_sum     = {1'b0, held_ff} + 4'd5;
   assign held_rem     = 3'(held_sum - 4'd8);

   always_comb begin
      buffer_in  = buffer_ff;
      held_in    = held_ff;
      count_in   = count_ff;
      pad_in     = pad_ff;
      bad_in     = bad_ff;
      started_in = started_ff;
      space_in   = space_ff;
      entry_c    = '0;

      if (carries_ff && !pad_ff && !bad_ff) begin
         if (is_blank(char_ff)) begin
            if (started_ff) begin
               space_in = 1'b1;
            end
         end else begin
            started_in = 1'b1;
            if (space_ff) begin
               bad_in = 1'b1;
            end else if (char_ff == CHAR_PAD) begin
               pad_in = 1'b1;
            end else if (!sym[SymbolWidth]) begin
               bad_in = 1'b1;
            end else begin
               buffer_in = buffer_shift;
               if (held_sum >= 4'd8) begin
                  held_in            = held_rem;
                  entry_c.has_byte   = 1'b1;
                  entry_c.data_byte  = 8'(buffer_shift >> held_rem);
                  if (count_ff != CountMax) begin
                     count_in = count_ff + 7'd1;
                  end
               end else begin
                  held_in = held_sum[HeldWidth-1:0];
               end
            end
         end
      end

      if (end_ff) begin
         entry_c.has_status = 1'b1;
         if (bad_in) begin
            entry_c.status_code = STATUS_INVALID;
         end else if (count_in != expected_bytes) begin
            entry_c.status_code = STATUS_COUNT;
         end else begin
            entry_c.status_code = STATUS_OK;
         end
         buffer_in  = '0;
         held_in    = '0;
         count_in   = '0;
         pad_in     = 1'b0;
         bad_in     = 1'b0;
         started_in = 1'b0;
         space_in   = 1'b0;
      end
   end

   assign produces    = entry_c.has_byte || entry_c.has_status;
   assign entry_valid = in_valid_ff && produces;
   assign advance     = in_valid_ff && (!produces || entry_ready);
   assign req.ready   = !in_valid_ff || advance;
   assign entry       = entry_c;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         buffer_ff   <= '0;
         held_ff     <= '0;
         count_ff    <= '0;
         pad_ff      <= 1'b0;
         bad_ff      <= 1'b0;
         started_ff  <= 1'b0;
         space_ff    <= 1'b0;
      end else begin
         if (req.ready) begin
            in_valid_ff <= req.valid;
         end
         if (advance) begin
            buffer_ff  <= buffer_in;
            held_ff    <= held_in;
            count_ff   <= count_in;
            pad_ff     <= pad_in;
            bad_ff     <= bad_in;
            started_ff <= started_in;
            space_ff   <= space_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         char_ff    <= req.char_code;
         carries_ff <= req.carries_char;
         end_ff     <= req.text_end;
      end
   end

endmodule

[hw/rtl/b32h_emit.sv]
`timescale 1ns / 1ps

module b32h_emit (
   input  logic                clock,
   input  logic                reset,
   input  b32h_pkg::entry_type entry,
   input  logic                entry_valid,
   output logic                entry_ready,
   b32h_rsp_if.source          rsp
);
   import b32h_pkg::*;

   entry_type  entry_ff;
   logic       busy_ff, busy_in;
   logic [1:0] phase_ff, phase_in;
   logic [1:0] parts;
   logic       last;
   logic       load;

   assign parts       = {entry_ff.has_byte, 1'b0} + {1'b0, entry_ff.has_status};
   assign last        = (phase_ff == parts - 2'd1);
   assign entry_ready = !busy_ff || (last && rsp.ready);
   assign load        = entry_valid && entry_ready;

   always_comb begin
      busy_in  = busy_ff;
      phase_in = phase_ff;
      if (busy_ff && rsp.ready) begin
         phase_in = phase_ff + 2'd1;
         if (last) begin
            busy_in = 1'b0;
         end
      end
      if (load) begin
         busy_in  = 1'b1;
         phase_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         phase_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         entry_ff <= entry;
      end
   end

   always_comb begin
      rsp.out_char    = '0;
      rsp.is_status   = 1'b1;
      rsp.status_code = entry_ff.status_code;
      if (entry_ff.has_byte && phase_ff == 2'd0) begin
         rsp.out_char    = hex_digit(entry_ff.data_byte[7:4]);
         rsp.is_status   = 1'b0;
         rsp.status_code = STATUS_OK;
      end else if (entry_ff.has_byte && phase_ff == 2'd1) begin
         rsp.out_char    = hex_digit(entry_ff.data_byte[3:0]);
         rsp.is_status   = 1'b0;
         rsp.status_code = STATUS_OK;
      end
   end

   assign rsp.valid   = busy_ff;
   assign rsp.run_end = last;

endmodule

[hw/rtl/base32_to_hex_decoder.sv]
`timescale 1ns / 1ps

// Streaming base32 to hex decoder.
// req: one transaction per text character (char_code, carries_char) and/or
//   end-of-text marker (text_end). Whitespace around the text is skipped,
//   '=' stops decoding, anything else invalid latches an error.
// rsp: each completed byte gives two transactions, lowercase hex high nibble
//   first; text_end adds one status transaction (ok / invalid char / wrong
//   byte count vs expected_bytes). run_end flags the last transaction
//   caused by a request.
// CSR: expected_bytes at byte address 0 (7 bits, reset 20), APB writes.
// Path: the first rsp transaction of a request becomes valid once it has
//   passed the input register and then the result register.
// Throughput: a request is taken every cycle while the response side keeps
//   up; a request producing several results holds the result register until
//   its last rsp transaction is taken, so a byte costs two rsp transactions.
// Stall: rsp.ready low holds the result register; a request with output then
//   waits in the input register and req.ready drops. Nothing is lost.
// Reset: clears all decode state, empties both registers, expected_bytes=20.

module base32_to_hex_decoder (
   input  logic                              clock,
   input  logic                              reset,
   b32h_req_if.sink                          req,
   b32h_rsp_if.source                        rsp,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [b32h_pkg::CsrAddrWidth-1:0] paddr,
   input  logic [b32h_pkg::CsrDataWidth-1:0] pwdata,
   output logic [b32h_pkg::CsrDataWidth-1:0] prdata,
   output logic                              pready
);
   import b32h_pkg::*;

   logic [CountWidth-1:0] expected_bytes;
   entry_type             entry;
   logic                  entry_valid;
   logic                  entry_ready;

   b32h_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready),
      .expected_bytes (expected_bytes)
   );

   // decode stage: input register plus decoder state
   b32h_decode u_decode (
      .clock          (clock),
      .reset          (reset),
      .req            (req),
      .expected_bytes (expected_bytes),
      .entry          (entry),
      .entry_valid    (entry_valid),
      .entry_ready    (entry_ready)
   );

   // result register, serializes up to three transactions per entry
   b32h_emit u_emit (
      .clock       (clock),
      .reset       (reset),
      .entry       (entry),
      .entry_valid (entry_valid),
      .entry_ready (entry_ready),
      .rsp         (rsp)
   );

endmodule
